FILE: rtl/core/sound_direction_peak_steer_unit_macros.svh
// ---------------------------------------------------------------------------
// sound_direction_peak_steer_unit_macros.svh
// Assertion macros shared by the peak steer core. Uses clk and rst_n of the
// module that includes it.
// ---------------------------------------------------------------------------
`ifndef SOUND_DIRECTION_PEAK_STEER_UNIT_MACROS_SVH
`define SOUND_DIRECTION_PEAK_STEER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define SDPS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SDPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define SDPS_ASSERT_IMPL(lbl, ante, cons, msg)
`define SDPS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: rtl/core/sdps_pkg.sv
// ---------------------------------------------------------------------------
// sdps_pkg
// Types, widths and codes for the sound direction peak steer core.
// ---------------------------------------------------------------------------
package sdps_pkg;

  localparam int MAG_PORT_W   = 32;
  localparam int BIN_W        = 10;
  localparam int PBIN_W       = 11;  // signed peak bin, -1 when none
  localparam int SPEED_W      = 11;
  localparam int MOTOR_W      = 12;
  localparam int NUM_CH       = 4;
  localparam int CFG_IDX_W    = 3;
  localparam int MAG_BITS_DEF = 32;

  localparam int unsigned BIN_COUNT = 1024;

  localparam logic [MAG_PORT_W-1:0] MIN_PEAK_RST   = 32'd10000;
  localparam logic [BIN_W-1:0]      FIRST_BIN_RST  = 10'd10;
  localparam logic [BIN_W-1:0]      FINAL_BIN_RST  = 10'd45;
  localparam logic [BIN_W-1:0]      MOVE_LIMIT_RST = 10'd30;
  localparam logic [SPEED_W-1:0]    DRIVE_SPD_RST  = 11'd800;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_PEAK    = 3'd0,
    CFG_FIRST_BIN   = 3'd1,
    CFG_FINAL_BIN   = 3'd2,
    CFG_MOVE_LIMIT  = 3'd3,
    CFG_DRIVE_SPEED = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CHAN_RIGHT = 2'd0,
    CHAN_LEFT  = 2'd1,
    CHAN_BACK  = 2'd2,
    CHAN_FRONT = 2'd3
  } mic_t;

  typedef struct packed {
    logic [MAG_PORT_W-1:0] min_peak;
    logic [BIN_W-1:0]      first_bin;
    logic [BIN_W-1:0]      final_bin;
    logic [BIN_W-1:0]      move_limit;
    logic [SPEED_W-1:0]    drive_speed;
  } sdps_cfg_t;

  // per-frame snapshot of the trackers, handed to the steer stage
  typedef struct packed {
    logic [NUM_CH-1:0][MAG_PORT_W-1:0] level;
    logic [NUM_CH-1:0][PBIN_W-1:0]     bin;
  } sdps_frame_t;

endpackage

FILE: rtl/core/sound_direction_peak_steer_unit.sv
// ---------------------------------------------------------------------------
// sound_direction_peak_steer_unit
// Per-bin peak tracking over four microphones, loudest channel pick and
// smoothed peak bin steering of two motors, one result per frame.
// ---------------------------------------------------------------------------
//   port group  direction  handshake        moves
//   in_*        input      valid / stall    one spectrum bin
//   out_*       output     valid / stall    one steer result per frame
//   cfg_*       input      valid / ready    one register write
//
// One bin per cycle unless stalled. A bin sits in the input register for its
// tracker update; a last bin then passes on to the snapshot and result registers.
// Synchronous active-low reset restores register defaults and restarts the
// trackers and the smoothing history. A stalled result keeps the next frame
// snapshot waiting; a further last bin then stays in the input register and
// stalls the input. Bins that do not end a frame keep flowing until then.
// ---------------------------------------------------------------------------
module sound_direction_peak_steer_unit import sdps_pkg::*; #(
  parameter int MAG_BITS = MAG_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [BIN_W-1:0]          in_bin_index,
  input  logic [MAG_PORT_W-1:0]     in_mag_right,
  input  logic [MAG_PORT_W-1:0]     in_mag_left,
  input  logic [MAG_PORT_W-1:0]     in_mag_back,
  input  logic [MAG_PORT_W-1:0]     in_mag_front,
  input  logic                      in_end_of_frame,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [MOTOR_W-1:0] out_left_speed,
  output logic signed [MOTOR_W-1:0] out_right_speed,
  output logic [1:0]                out_loudest_mic,
  output logic signed [PBIN_W-1:0]  out_smoothed_bin,
  output logic                      out_moving,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [MAG_PORT_W-1:0]     cfg_data
);

  sdps_cfg_t                         cfg_r;
  logic [NUM_CH-1:0][MAG_PORT_W-1:0] mag;
  logic                              frm_valid, frm_ready;
  sdps_frame_t                       frm;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_peak    <= MIN_PEAK_RST;
      cfg_r.first_bin   <= FIRST_BIN_RST;
      cfg_r.final_bin   <= FINAL_BIN_RST;
      cfg_r.move_limit  <= MOVE_LIMIT_RST;
      cfg_r.drive_speed <= DRIVE_SPD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_MIN_PEAK:    cfg_r.min_peak    <= cfg_data;
        CFG_FIRST_BIN:   cfg_r.first_bin   <= cfg_data[BIN_W-1:0];
        CFG_FINAL_BIN:   cfg_r.final_bin   <= cfg_data[BIN_W-1:0];
        CFG_MOVE_LIMIT:  cfg_r.move_limit  <= cfg_data[BIN_W-1:0];
        CFG_DRIVE_SPEED: cfg_r.drive_speed <= cfg_data[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  assign mag[CHAN_RIGHT] = in_mag_right;
  assign mag[CHAN_LEFT]  = in_mag_left;
  assign mag[CHAN_BACK]  = in_mag_back;
  assign mag[CHAN_FRONT] = in_mag_front;

  sdps_track #(
    .MAG_BITS (MAG_BITS)
  ) u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_bin    (in_bin_index),
    .in_mag    (mag),
    .in_eof    (in_end_of_frame),
    .frm_valid (frm_valid),
    .frm_ready (frm_ready),
    .frm       (frm)
  );

  sdps_steer u_steer (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .frm_valid        (frm_valid),
    .frm_ready        (frm_ready),
    .frm              (frm),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_left_speed   (out_left_speed),
    .out_right_speed  (out_right_speed),
    .out_loudest_mic  (out_loudest_mic),
    .out_smoothed_bin (out_smoothed_bin),
    .out_moving       (out_moving)
  );

endmodule

FILE: rtl/core/sdps_track.sv
// ---------------------------------------------------------------------------
// sdps_track
// Input register and per-channel peak trackers. Emits a frame snapshot on
// the last bin of each frame and restarts the trackers.
// ---------------------------------------------------------------------------
`include "sound_direction_peak_steer_unit_macros.svh"

module sdps_track import sdps_pkg::*; #(
  parameter int MAG_BITS = MAG_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  sdps_cfg_t                         cfg,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [BIN_W-1:0]                  in_bin,
  input  logic [NUM_CH-1:0][MAG_PORT_W-1:0] in_mag,
  input  logic                              in_eof,
  output logic                              frm_valid,
  input  logic                              frm_ready,
  output sdps_frame_t                       frm
);

  localparam int LVL_W = (MAG_BITS < MAG_PORT_W) ? MAG_BITS : MAG_PORT_W;

  logic                         s1_vld_r, s1_vld_nxt;
  logic [BIN_W-1:0]             bin_r;
  logic [NUM_CH-1:0][LVL_W-1:0] mag_r;
  logic                         eof_r;

  logic [NUM_CH-1:0][LVL_W-1:0] lvl_r, lvl_nxt;
  logic [NUM_CH-1:0]            pk_vld_r, pk_vld_nxt;
  logic [NUM_CH-1:0][BIN_W-1:0] pk_bin_r, pk_bin_nxt;

  logic                         frm_vld_r, frm_vld_nxt;
  sdps_frame_t                  frm_r, frm_nxt;

  logic                         go, in_acc, frm_take, in_win;
  logic [LVL_W-1:0]             floor_lvl;
  logic [NUM_CH-1:0][LVL_W-1:0] cur_lvl, upd_lvl;
  logic [NUM_CH-1:0]            hit, upd_vld;
  logic [NUM_CH-1:0][BIN_W-1:0] upd_bin;

  assign floor_lvl = cfg.min_peak[LVL_W-1:0];
  assign in_win    = (bin_r >= cfg.first_bin) && (bin_r <= cfg.final_bin) &&
                     (32'(bin_r) < BIN_COUNT);

  assign frm_take = frm_vld_r && frm_ready;
  // an end-of-frame item needs the snapshot register free
  assign go       = s1_vld_r && (!eof_r || !frm_vld_r || frm_take);
  assign in_stall = s1_vld_r && !go;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      cur_lvl[c] = pk_vld_r[c] ? lvl_r[c] : floor_lvl;
      hit[c]     = in_win && (mag_r[c] > cur_lvl[c]);
      upd_lvl[c] = hit[c] ? mag_r[c] : cur_lvl[c];
      upd_vld[c] = pk_vld_r[c] || hit[c];
      upd_bin[c] = hit[c] ? bin_r : pk_bin_r[c];
    end
  end

  always_comb begin
    s1_vld_nxt  = in_acc ? 1'b1 : (go ? 1'b0 : s1_vld_r);
    lvl_nxt     = lvl_r;
    pk_vld_nxt  = pk_vld_r;
    pk_bin_nxt  = pk_bin_r;
    frm_vld_nxt = frm_take ? 1'b0 : frm_vld_r;
    frm_nxt     = frm_r;
    if (go) begin
      lvl_nxt    = upd_lvl;
      pk_bin_nxt = upd_bin;
      pk_vld_nxt = eof_r ? '0 : upd_vld;
      if (eof_r) begin
        frm_vld_nxt = 1'b1;
        for (int c = 0; c < NUM_CH; c++) begin
          frm_nxt.level[c] = MAG_PORT_W'(upd_lvl[c]);
          frm_nxt.bin[c]   = upd_vld[c] ? {1'b0, upd_bin[c]} : '1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      pk_vld_r  <= '0;
      frm_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      pk_vld_r  <= pk_vld_nxt;
      frm_vld_r <= frm_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      bin_r <= in_bin;
      eof_r <= in_eof;
      for (int c = 0; c < NUM_CH; c++) begin
        mag_r[c] <= in_mag[c][LVL_W-1:0];
      end
    end
    lvl_r    <= lvl_nxt;
    pk_bin_r <= pk_bin_nxt;
    frm_r    <= frm_nxt;
  end

  assign frm_valid = frm_vld_r;
  assign frm       = frm_r;

  `SDPS_ASSERT_NEXT(a_frame_restart, go && eof_r, pk_vld_r == '0, "trackers not restarted")
  `SDPS_ASSERT_NEXT(a_idle_keeps_peaks, !go, $stable(pk_vld_r), "peaks moved without an item")
  `SDPS_ASSERT_NEXT(a_snapshot_loaded, go && eof_r, frm_vld_r, "frame snapshot missing")

endmodule

FILE: rtl/core/sdps_steer.sv
// ---------------------------------------------------------------------------
// sdps_steer
// Loudest channel pick, peak bin averaging and smoothing, motor command.
// Result register with stall handshake.
// ---------------------------------------------------------------------------
`include "sound_direction_peak_steer_unit_macros.svh"

module sdps_steer import sdps_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  sdps_cfg_t                 cfg,
  input  logic                      frm_valid,
  output logic                      frm_ready,
  input  sdps_frame_t               frm,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [MOTOR_W-1:0] out_left_speed,
  output logic signed [MOTOR_W-1:0] out_right_speed,
  output logic [1:0]                out_loudest_mic,
  output logic signed [PBIN_W-1:0]  out_smoothed_bin,
  output logic                      out_moving
);

  localparam int SUM_W = PBIN_W + 2;
  localparam int SM_W  = PBIN_W + 1;

  logic                      out_vld_r;
  logic signed [MOTOR_W-1:0] left_r, right_r, left_nxt, right_nxt;
  mic_t                      loud_r, loud_nxt;
  logic signed [PBIN_W-1:0]  smooth_r, prev_r, smooth_nxt, avg;
  logic                      moving_r, moving_nxt, take;

  logic signed [SUM_W-1:0]   bin_sum, sum_adj;
  logic signed [SM_W-1:0]    sm_sum, sm_adj;
  logic signed [MOTOR_W-1:0] spd, spd_neg;
  logic [NUM_CH-1:0][MAG_PORT_W-1:0] lv;

  assign frm_ready = !out_vld_r || !out_stall;
  assign take      = frm_valid && frm_ready;
  assign lv        = frm.level;

  always_comb begin
    if (lv[0] >= lv[1] && lv[0] >= lv[2] && lv[0] >= lv[3]) begin
      loud_nxt = CHAN_RIGHT;
    end else if (lv[1] >= lv[2] && lv[1] >= lv[3]) begin
      loud_nxt = CHAN_LEFT;
    end else if (lv[2] >= lv[3]) begin
      loud_nxt = CHAN_BACK;
    end else begin
      loud_nxt = CHAN_FRONT;
    end
  end

  // divisions truncate toward zero: bias negative sums before the shift
  always_comb begin
    bin_sum    = SUM_W'($signed(frm.bin[0])) + SUM_W'($signed(frm.bin[1])) +
                 SUM_W'($signed(frm.bin[2])) + SUM_W'($signed(frm.bin[3]));
    sum_adj    = bin_sum + (bin_sum[SUM_W-1] ? SUM_W'(3) : SUM_W'(0));
    avg        = PBIN_W'(sum_adj >>> 2);
    sm_sum     = SM_W'(avg) + SM_W'(prev_r);
    sm_adj     = sm_sum + (sm_sum[SM_W-1] ? SM_W'(1) : SM_W'(0));
    smooth_nxt = PBIN_W'(sm_adj >>> 1);
    moving_nxt = smooth_nxt > $signed({1'b0, cfg.move_limit});
  end

  always_comb begin
    spd       = $signed({1'b0, cfg.drive_speed});
    spd_neg   = -spd;
    left_nxt  = '0;
    right_nxt = '0;
    if (moving_nxt) begin
      case (loud_nxt) inside
        CHAN_FRONT: begin
          left_nxt  = spd;
          right_nxt = spd;
        end
        CHAN_BACK, CHAN_RIGHT: begin
          left_nxt  = spd;
          right_nxt = spd_neg;
        end
        default: begin
          left_nxt  = spd_neg;
          right_nxt = spd;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      prev_r    <= '0;
    end else begin
      if (take) begin
        out_vld_r <= 1'b1;
        prev_r    <= smooth_nxt;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      left_r   <= left_nxt;
      right_r  <= right_nxt;
      loud_r   <= loud_nxt;
      smooth_r <= smooth_nxt;
      moving_r <= moving_nxt;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_left_speed   = left_r;
  assign out_right_speed  = right_r;
  assign out_loudest_mic  = loud_r;
  assign out_smoothed_bin = smooth_r;
  assign out_moving       = moving_r;

  `SDPS_ASSERT_IMPL(a_stop_zero, out_vld_r && !moving_r, left_r == '0 && right_r == '0, "stopped but speed set")
  `SDPS_ASSERT_NEXT(a_prev_tracks_out, take, prev_r == smooth_r && out_vld_r, "history and result differ")
  `SDPS_ASSERT_IMPL(a_move_above_limit, out_vld_r && moving_r, smooth_r > $signed({1'b0, cfg.move_limit}), "moving at or below limit")

endmodule
